[rtl/aa8_pkg.sv]
// ----------------------------------------------------------------------------
// aa8_pkg: shared types and constants
// Widths, pipeline payload structs and angle constants for the pseudo-angle block.
// ----------------------------------------------------------------------------
package aa8_pkg;

    localparam int VEC_W   = 16;
    localparam int ANG_W   = 8;
    localparam int Q_BITS  = 7;
    localparam int REM_W   = 18;
    localparam int DEN_W   = 18;
    localparam int T_W     = 9;

    localparam logic signed [VEC_W-1:0] VEC_MIN  = 16'sh8000;
    localparam logic signed [VEC_W-1:0] VEC_SAT  = 16'sh8001;
    localparam logic [T_W-1:0]          BASE_POS = 9'd64;
    localparam logic [T_W-1:0]          BASE_NEG = 9'd192;
    localparam logic [ANG_W-1:0]        ANG_OFS  = 8'd128;

    typedef struct packed {
        logic zero;
        logic yneg;
        logic xneg;
        logic nneg;
    } t_ctl;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DEN_W-1:0]  den2;
        logic [Q_BITS-1:0] quo;
        t_ctl              ctl;
    } t_div;

endpackage

[rtl/aa8_prep.sv]
// ----------------------------------------------------------------------------
// aa8_prep: front stage
// Saturates the inputs, picks the half-plane and forms numerator and divisor.
// ----------------------------------------------------------------------------
module aa8_prep (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [aa8_pkg::VEC_W-1:0] i_vec_y,
    input  logic signed [aa8_pkg::VEC_W-1:0] i_vec_x,
    output logic                            o_valid,
    input  logic                            i_ready,
    output aa8_pkg::t_div                   o_div
);
    import aa8_pkg::*;

    logic                      r_valid;
    t_div                      r_div;
    t_div                      n_div;
    logic signed [VEC_W-1:0]   ys;
    logic signed [VEC_W-1:0]   xs;
    logic signed [VEC_W+1:0]   ay;
    logic signed [VEC_W+1:0]   xe;
    logic signed [VEC_W+1:0]   num;
    logic signed [VEC_W+1:0]   den;
    logic [VEC_W+1:0]          anum;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        ys  = (i_vec_y == VEC_MIN) ? VEC_SAT : i_vec_y;
        xs  = (i_vec_x == VEC_MIN) ? VEC_SAT : i_vec_x;
        ay  = ys[VEC_W-1] ? -(18'(ys)) : 18'(ys);
        xe  = 18'(xs);
        if (xs[VEC_W-1]) begin
            num = xe + ay;
            den = ay - xe;
        end else begin
            num = xe - ay;
            den = xe + ay;
        end
        anum = num[VEC_W+1] ? 18'(-num) : 18'(num);
        n_div.rem      = anum[REM_W-1:0];
        n_div.den2     = {den[DEN_W-2:0], 1'b0};
        n_div.quo      = '0;
        n_div.ctl.zero = (xs == '0) && (ys == '0);
        n_div.ctl.yneg = ys[VEC_W-1];
        n_div.ctl.xneg = xs[VEC_W-1];
        n_div.ctl.nneg = num[VEC_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

[rtl/aa8_divstep.sv]
// ----------------------------------------------------------------------------
// aa8_divstep: one restoring division stage
// Doubles the remainder, compares with the doubled divisor, yields one quotient bit.
// ----------------------------------------------------------------------------
module aa8_divstep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  aa8_pkg::t_div i_div,
    output logic          o_valid,
    input  logic          i_ready,
    output aa8_pkg::t_div o_div
);
    import aa8_pkg::*;

    logic             r_valid;
    t_div             r_div;
    t_div             n_div;
    logic [REM_W:0]   rem2;
    logic [REM_W:0]   diff;
    logic             ge;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        rem2  = {i_div.rem, 1'b0};
        ge    = rem2 >= {1'b0, i_div.den2};
        diff  = rem2 - {1'b0, i_div.den2};
        n_div = i_div;
        n_div.rem = ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
        n_div.quo = {i_div.quo[Q_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

[rtl/aa8_post.sv]
// ----------------------------------------------------------------------------
// aa8_post: output stage
// Turns the signed quotient into the angle, mirrors for negative y, registers it.
// ----------------------------------------------------------------------------
module aa8_post (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  aa8_pkg::t_div               i_div,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [aa8_pkg::ANG_W-1:0]   o_angle
);
    import aa8_pkg::*;

    logic             r_valid;
    logic [ANG_W-1:0] r_angle;
    logic [ANG_W-1:0] n_angle;
    logic [T_W-1:0]   base;
    logic [T_W-1:0]   quo;
    logic [T_W-1:0]   t;
    logic [ANG_W-1:0] ang;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        base = i_div.ctl.xneg ? BASE_NEG : BASE_POS;
        quo  = T_W'(i_div.quo);
        t    = i_div.ctl.nneg ? base + quo : base - quo;
        ang  = t[T_W-1:1] + ANG_OFS;
        if (i_div.ctl.zero) begin
            n_angle = '0;
        end else if (i_div.ctl.yneg) begin
            n_angle = 8'd0 - ang;
        end else begin
            n_angle = ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

endmodule

[rtl/approx_atan2_angle8_top.sv]
// ----------------------------------------------------------------------------
// approx_atan2_angle8_top: 8-bit pseudo-angle of a signed 16-bit vector
// Pipeline: prep, 7 divide and output stages, each registered.
// Throughput: one vector per cycle; each stage holds under back-pressure.
// Bubbles are squeezed out: a stage takes data whenever it is empty.
// Reset: synchronous, active low; clears all stage valid bits.
// ----------------------------------------------------------------------------
module approx_atan2_angle8_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] vec_y, [31:16] vec_x
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] angle
);
    import aa8_pkg::*;

    logic              v   [Q_BITS+1];
    logic              rdy [Q_BITS+1];
    t_div              d   [Q_BITS+1];

    aa8_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_vec_y (s_axis_tdata[15:0]),
        .i_vec_x (s_axis_tdata[31:16]),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_div   (d[0])
    );

    for (genvar g = 0; g < Q_BITS; g++) begin : g_div
        aa8_divstep u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g]),
            .o_ready (rdy[g]),
            .i_div   (d[g]),
            .o_valid (v[g+1]),
            .i_ready (rdy[g+1]),
            .o_div   (d[g+1])
        );
    end

    aa8_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[Q_BITS]),
        .o_ready (rdy[Q_BITS]),
        .i_div   (d[Q_BITS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_angle (m_axis_tdata)
    );

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v[Q_BITS] && !d[Q_BITS].ctl.zero) |-> (d[Q_BITS].quo <= 7'd64))
        else $error("quotient out of range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v[Q_BITS] && !d[Q_BITS].ctl.zero) |-> (d[Q_BITS].rem < d[Q_BITS].den2))
        else $error("remainder not below divisor");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (v[0] && v[Q_BITS] && m_axis_tvalid))
        else $error("input stalled with an empty stage");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v[0] && !d[0].ctl.zero) |-> (d[0].den2 != '0))
        else $error("zero divisor on a non-zero vector");

endmodule
